### src/prdt_pkg.sv
package prdt_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int THR_W      = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int NUM_CFG    = 4;
  localparam int MUL_CNT_W  = 2;

  localparam int PIDX_W     = 10;
  localparam int POS_W      = 12;
  localparam int TIME_W     = 13;
  localparam int FLAGS_W    = 4;
  localparam int OUT_PAD_W  = 7;
  localparam int OUT_DATA_W = 112;

  // register indexes, also the slot of each threshold
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_HIGH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LOW   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LOW  = 8'd3;

  localparam logic [MUL_CNT_W-1:0] THR_RISE_HIGH  = 2'd0;
  localparam logic [MUL_CNT_W-1:0] THR_RISE_LOW   = 2'd1;
  localparam logic [MUL_CNT_W-1:0] THR_DECAY_HIGH = 2'd2;
  localparam logic [MUL_CNT_W-1:0] THR_DECAY_LOW  = 2'd3;
  localparam logic [MUL_CNT_W-1:0] THR_LAST       = 2'd3;

  localparam logic [FRAC_W-1:0] RISE_HIGH_RST  = 16'd58982;
  localparam logic [FRAC_W-1:0] RISE_LOW_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DECAY_HIGH_RST = 16'd58982;
  localparam logic [FRAC_W-1:0] DECAY_LOW_RST  = 16'd13107;

  localparam logic signed [SAMPLE_W-1:0] PEAK_RST = 16'sh8000;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MUL,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scan;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

### src/pulse_rise_decay_time.sv
// pulse rise and decay time measurement
// load: one sample word a cycle, s_tready high while the block collects a pulse
// after the last word of a pulse of n stored samples the block forms the four
// threshold products on one multiplier, reads the n samples on the single read
// port, passes a drain state, then waits in an output state for a free output
// register and registers the result word; rst clears the fractions to their
// defaults and empties the pulse state at once, the store needs no clearing
module pulse_rise_decay_time #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // sample
  input  logic         s_tlast,   // last_sample
  output logic         m_tvalid,
  input  logic         m_tready,
  // peak_index, peak_value, rise_high_pos, rise_low_pos, decay_high_pos,
  // decay_low_pos, rise_time, decay_time, found_flags, overflow, zero fill
  output logic [111:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  prdt_pkg::cmd_t cmd;
  prdt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  prdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prdt_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    ($signed(s_tdata)),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

### src/prdt_ctrl.sv
module prdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  input  prdt_pkg::sts_t sts,
  output prdt_pkg::cmd_t cmd
);

  prdt_pkg::state_t state;
  prdt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prdt_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      prdt_pkg::S_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = prdt_pkg::S_MUL;
        end
      end
      prdt_pkg::S_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_done) begin
          state_next = prdt_pkg::S_SCAN;
        end
      end
      prdt_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = prdt_pkg::S_DRAIN;
        end
      end
      prdt_pkg::S_DRAIN: begin
        state_next = prdt_pkg::S_OUT;
      end
      prdt_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = prdt_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = prdt_pkg::S_LOAD;
      end
    endcase
  end

endmodule

### src/prdt_dp.sv
module prdt_dp #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  prdt_pkg::cmd_t                       cmd,
  output prdt_pkg::sts_t                       sts,
  input  logic signed [prdt_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 cfg_wr,
  input  logic [prdt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prdt_pkg::FRAC_W-1:0]          cfg_data,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [prdt_pkg::OUT_DATA_W-1:0]      m_tdata
);

  localparam int IDXW = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int PW   = CW + 1;
  localparam int WX   = (PW > prdt_pkg::TIME_W) ? PW : prdt_pkg::TIME_W;
  localparam int PXW  = (IDXW > prdt_pkg::PIDX_W) ? IDXW : prdt_pkg::PIDX_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES);

  logic signed [prdt_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];

  logic [prdt_pkg::FRAC_W-1:0]        frac [prdt_pkg::NUM_CFG];
  logic signed [prdt_pkg::THR_W-1:0]  thr  [prdt_pkg::NUM_CFG];
  logic [IDXW-1:0]                    pos  [prdt_pkg::NUM_CFG];
  logic [prdt_pkg::NUM_CFG-1:0]       found;

  logic [CW-1:0]                        count;
  logic signed [prdt_pkg::SAMPLE_W-1:0] peak_val;
  logic [IDXW-1:0]                      peak_idx;
  logic                                 dropped;

  logic [prdt_pkg::MUL_CNT_W-1:0] mul_cnt;
  logic signed [32:0]             prod;

  logic [IDXW-1:0]                      scan_idx;
  logic                                 rd_vld;
  logic [IDXW-1:0]                      rd_idx;
  logic signed [prdt_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [prdt_pkg::THR_W-1:0]    rd_ext;
  logic [prdt_pkg::NUM_CFG-1:0]         hit;
  logic                                 at_or_before;
  logic                                 at_or_after;

  logic [WX-1:0]  rh_full;
  logic [WX-1:0]  rl_full;
  logic [WX-1:0]  dh_full;
  logic [WX-1:0]  dl_full;
  logic [WX-1:0]  rt_full;
  logic [WX-1:0]  dt_full;
  logic [PXW-1:0] pidx_full;
  logic [prdt_pkg::FLAGS_W-1:0] flags;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frac[prdt_pkg::THR_RISE_HIGH]  <= prdt_pkg::RISE_HIGH_RST;
      frac[prdt_pkg::THR_RISE_LOW]   <= prdt_pkg::RISE_LOW_RST;
      frac[prdt_pkg::THR_DECAY_HIGH] <= prdt_pkg::DECAY_HIGH_RST;
      frac[prdt_pkg::THR_DECAY_LOW]  <= prdt_pkg::DECAY_LOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        prdt_pkg::CFG_RISE_HIGH:  frac[prdt_pkg::THR_RISE_HIGH]  <= cfg_data;
        prdt_pkg::CFG_RISE_LOW:   frac[prdt_pkg::THR_RISE_LOW]   <= cfg_data;
        prdt_pkg::CFG_DECAY_HIGH: frac[prdt_pkg::THR_DECAY_HIGH] <= cfg_data;
        prdt_pkg::CFG_DECAY_LOW:  frac[prdt_pkg::THR_DECAY_LOW]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CAP)) begin
      mem[count[IDXW-1:0]] <= sample;
    end
    if (cmd.scan) begin
      rd_data <= mem[scan_idx];
    end
  end

  // running pulse state
  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      count    <= '0;
      peak_val <= prdt_pkg::PEAK_RST;
      peak_idx <= '0;
      dropped  <= 1'b0;
    end else if (cmd.load) begin
      if (count < CAP) begin
        count <= count + CW'(1);
        if (sample > peak_val) begin
          peak_val <= sample;
          peak_idx <= count[IDXW-1:0];
        end
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // thresholds: floor(frac * peak / 2^16), one product a cycle
  assign prod = $signed({1'b0, frac[mul_cnt]}) * peak_val;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      thr[mul_cnt] <= prod[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      mul_cnt <= '0;
    end else if (cmd.mul) begin
      mul_cnt <= mul_cnt + prdt_pkg::MUL_CNT_W'(1);
    end
  end

  // ascending scan over the whole pulse
  always_ff @(posedge clk) begin
    if (rst || cmd.mul) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
    end
    rd_idx <= scan_idx;
  end

  assign rd_ext       = {rd_data[prdt_pkg::SAMPLE_W-1], rd_data};
  assign at_or_before = (rd_idx <= peak_idx);
  assign at_or_after  = (rd_idx >= peak_idx);

  always_comb begin
    for (int k = 0; k < prdt_pkg::NUM_CFG; k++) begin
      hit[k] = (rd_ext <= thr[k]);
    end
  end

  // rise keeps the latest hit at or before the peak, decay the first at or after it
  always_ff @(posedge clk) begin
    if (rst || cmd.mul) begin
      found <= '0;
    end else if (rd_vld) begin
      if (at_or_before && hit[prdt_pkg::THR_RISE_HIGH]) begin
        found[prdt_pkg::THR_RISE_HIGH] <= 1'b1;
        pos[prdt_pkg::THR_RISE_HIGH]   <= rd_idx;
      end
      if (at_or_before && hit[prdt_pkg::THR_RISE_LOW]) begin
        found[prdt_pkg::THR_RISE_LOW] <= 1'b1;
        pos[prdt_pkg::THR_RISE_LOW]   <= rd_idx;
      end
      if (at_or_after && hit[prdt_pkg::THR_DECAY_HIGH] &&
          !found[prdt_pkg::THR_DECAY_HIGH]) begin
        found[prdt_pkg::THR_DECAY_HIGH] <= 1'b1;
        pos[prdt_pkg::THR_DECAY_HIGH]   <= rd_idx;
      end
      if (at_or_after && hit[prdt_pkg::THR_DECAY_LOW] &&
          !found[prdt_pkg::THR_DECAY_LOW]) begin
        found[prdt_pkg::THR_DECAY_LOW] <= 1'b1;
        pos[prdt_pkg::THR_DECAY_LOW]   <= rd_idx;
      end
    end
  end

  // half-bin positions, axis edge when not found
  assign rh_full = found[prdt_pkg::THR_RISE_HIGH] ?
                   WX'({pos[prdt_pkg::THR_RISE_HIGH], 1'b1}) : '0;
  assign rl_full = found[prdt_pkg::THR_RISE_LOW] ?
                   WX'({pos[prdt_pkg::THR_RISE_LOW], 1'b1}) : '0;
  assign dh_full = found[prdt_pkg::THR_DECAY_HIGH] ?
                   WX'({pos[prdt_pkg::THR_DECAY_HIGH], 1'b1}) : WX'({count, 1'b0});
  assign dl_full = found[prdt_pkg::THR_DECAY_LOW] ?
                   WX'({pos[prdt_pkg::THR_DECAY_LOW], 1'b1}) : WX'({count, 1'b0});
  assign rt_full   = rh_full - rl_full;
  assign dt_full   = dl_full - dh_full;
  assign pidx_full = PXW'(peak_idx);
  assign flags     = {found[prdt_pkg::THR_DECAY_LOW], found[prdt_pkg::THR_RISE_LOW],
                      found[prdt_pkg::THR_DECAY_HIGH], found[prdt_pkg::THR_RISE_HIGH]};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.publish) begin
      m_tdata <= {{prdt_pkg::OUT_PAD_W{1'b0}}, dropped, flags,
                  dt_full[prdt_pkg::TIME_W-1:0], rt_full[prdt_pkg::TIME_W-1:0],
                  dl_full[prdt_pkg::POS_W-1:0], dh_full[prdt_pkg::POS_W-1:0],
                  rl_full[prdt_pkg::POS_W-1:0], rh_full[prdt_pkg::POS_W-1:0],
                  peak_val, pidx_full[prdt_pkg::PIDX_W-1:0]};
    end
  end

  assign sts.mul_done  = (mul_cnt == prdt_pkg::THR_LAST);
  assign sts.scan_last = ((CW'(scan_idx) + CW'(1)) == count);
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

### test/pulse_timing_checker.sv
`timescale 1ns / 1ps

module pulse_timing_checker #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [prdt_pkg::SAMPLE_W-1:0]   s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [prdt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [prdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prdt_pkg::FRAC_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending
);

  // bit offsets inside the result word
  localparam int PV_LSB  = prdt_pkg::PIDX_W;
  localparam int RHP_LSB = PV_LSB + prdt_pkg::SAMPLE_W;
  localparam int RLP_LSB = RHP_LSB + prdt_pkg::POS_W;
  localparam int DHP_LSB = RLP_LSB + prdt_pkg::POS_W;
  localparam int DLP_LSB = DHP_LSB + prdt_pkg::POS_W;
  localparam int RT_LSB  = DLP_LSB + prdt_pkg::POS_W;
  localparam int DT_LSB  = RT_LSB + prdt_pkg::TIME_W;
  localparam int FL_LSB  = DT_LSB + prdt_pkg::TIME_W;
  localparam int OV_LSB  = FL_LSB + prdt_pkg::FLAGS_W;

  localparam int FLAG_RISE_HIGH  = 0;
  localparam int FLAG_DECAY_HIGH = 1;
  localparam int FLAG_RISE_LOW   = 2;
  localparam int FLAG_DECAY_LOW  = 3;

  typedef struct {
    logic [prdt_pkg::PIDX_W-1:0]          peak_index;
    logic signed [prdt_pkg::SAMPLE_W-1:0] peak_value;
    logic [prdt_pkg::POS_W-1:0]           rise_high_pos;
    logic [prdt_pkg::POS_W-1:0]           rise_low_pos;
    logic [prdt_pkg::POS_W-1:0]           decay_high_pos;
    logic [prdt_pkg::POS_W-1:0]           decay_low_pos;
    logic signed [prdt_pkg::TIME_W-1:0]   rise_time;
    logic signed [prdt_pkg::TIME_W-1:0]   decay_time;
    logic [prdt_pkg::FLAGS_W-1:0]         found_flags;
    logic                                 overflow;
  } pulse_meas_t;

  logic [prdt_pkg::FRAC_W-1:0]          frac [prdt_pkg::NUM_CFG];
  logic signed [prdt_pkg::SAMPLE_W-1:0] store [MAX_SAMPLES];
  int                                   count;
  int                                   peak_val;
  int                                   peak_idx;
  bit                                   dropped;
  pulse_meas_t                          pending_measurements [$];

  function automatic bit at_or_below(logic signed [prdt_pkg::SAMPLE_W-1:0] s,
                                     logic [prdt_pkg::FRAC_W-1:0] f);
    return longint'(s) * 65536 <= longint'(f) * peak_val;
  endfunction

  function automatic int crossing_pos(logic [prdt_pkg::FRAC_W-1:0] f, bit toward_start,
                                      output bit found);
    int i;
    found = 1'b0;
    if (toward_start) begin
      for (i = peak_idx; i >= 0; i--) begin
        if (at_or_below(store[i], f)) begin
          found = 1'b1;
          return 2 * i + 1;
        end
      end
      return 0;
    end
    for (i = peak_idx; i < count; i++) begin
      if (at_or_below(store[i], f)) begin
        found = 1'b1;
        return 2 * i + 1;
      end
    end
    return 2 * count;
  endfunction

  function automatic pulse_meas_t measure_pulse();
    pulse_meas_t r;
    int rh, rl, dh, dl, rt, dt;
    bit f_rh, f_rl, f_dh, f_dl;
    rh = crossing_pos(frac[prdt_pkg::CFG_RISE_HIGH], 1'b1, f_rh);
    rl = crossing_pos(frac[prdt_pkg::CFG_RISE_LOW], 1'b1, f_rl);
    dh = crossing_pos(frac[prdt_pkg::CFG_DECAY_HIGH], 1'b0, f_dh);
    dl = crossing_pos(frac[prdt_pkg::CFG_DECAY_LOW], 1'b0, f_dl);
    rt = rh - rl;
    dt = dl - dh;
    r.peak_index     = peak_idx[prdt_pkg::PIDX_W-1:0];
    r.peak_value     = peak_val[prdt_pkg::SAMPLE_W-1:0];
    r.rise_high_pos  = rh[prdt_pkg::POS_W-1:0];
    r.rise_low_pos   = rl[prdt_pkg::POS_W-1:0];
    r.decay_high_pos = dh[prdt_pkg::POS_W-1:0];
    r.decay_low_pos  = dl[prdt_pkg::POS_W-1:0];
    r.rise_time      = rt[prdt_pkg::TIME_W-1:0];
    r.decay_time     = dt[prdt_pkg::TIME_W-1:0];
    r.found_flags    = '0;
    r.found_flags[FLAG_RISE_HIGH]  = f_rh;
    r.found_flags[FLAG_DECAY_HIGH] = f_dh;
    r.found_flags[FLAG_RISE_LOW]   = f_rl;
    r.found_flags[FLAG_DECAY_LOW]  = f_dl;
    r.overflow       = dropped;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pulse_meas_t want, got;
    logic signed [prdt_pkg::SAMPLE_W-1:0] smp;
    if (rst) begin
      frac[prdt_pkg::CFG_RISE_HIGH]  = prdt_pkg::RISE_HIGH_RST;
      frac[prdt_pkg::CFG_RISE_LOW]   = prdt_pkg::RISE_LOW_RST;
      frac[prdt_pkg::CFG_DECAY_HIGH] = prdt_pkg::DECAY_HIGH_RST;
      frac[prdt_pkg::CFG_DECAY_LOW]  = prdt_pkg::DECAY_LOW_RST;
      count    = 0;
      peak_val = -32768;
      peak_idx = 0;
      dropped  = 1'b0;
      fail_count = 0;
      pending_measurements.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < prdt_pkg::NUM_CFG) begin
        frac[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        smp = s_tdata;
        if (count < MAX_SAMPLES) begin
          store[count] = smp;
          if (int'(smp) > peak_val) begin
            peak_val = smp;
            peak_idx = count;
          end
          count++;
        end else begin
          dropped = 1'b1;
        end
        if (s_tlast) begin
          pending_measurements.push_back(measure_pulse());
          count    = 0;
          peak_val = -32768;
          peak_idx = 0;
          dropped  = 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_measurements.size() == 0) begin
          $error("result word with no pulse pending");
          fail_count++;
        end else begin
          want = pending_measurements.pop_front();
          got.peak_index     = m_tdata[PV_LSB-1:0];
          got.peak_value     = m_tdata[RHP_LSB-1:PV_LSB];
          got.rise_high_pos  = m_tdata[RLP_LSB-1:RHP_LSB];
          got.rise_low_pos   = m_tdata[DHP_LSB-1:RLP_LSB];
          got.decay_high_pos = m_tdata[DLP_LSB-1:DHP_LSB];
          got.decay_low_pos  = m_tdata[RT_LSB-1:DLP_LSB];
          got.rise_time      = m_tdata[DT_LSB-1:RT_LSB];
          got.decay_time     = m_tdata[FL_LSB-1:DT_LSB];
          got.found_flags    = m_tdata[OV_LSB-1:FL_LSB];
          got.overflow       = m_tdata[OV_LSB];
          check_field("peak_index", want.peak_index, got.peak_index);
          check_field("peak_value", want.peak_value, got.peak_value);
          check_field("rise_high_pos", want.rise_high_pos, got.rise_high_pos);
          check_field("rise_low_pos", want.rise_low_pos, got.rise_low_pos);
          check_field("decay_high_pos", want.decay_high_pos, got.decay_high_pos);
          check_field("decay_low_pos", want.decay_low_pos, got.decay_low_pos);
          check_field("rise_time", want.rise_time, got.rise_time);
          check_field("decay_time", want.decay_time, got.decay_time);
          check_field("found_flags", want.found_flags, got.found_flags);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      pending <= pending_measurements.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = 1024;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [prdt_pkg::SAMPLE_W-1:0]   s_tdata = '0;   // sample
  logic                            s_tlast = 1'b0; // last_sample
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // peak_index, peak_value, rise_high_pos, rise_low_pos, decay_high_pos,
  // decay_low_pos, rise_time, decay_time, found_flags, overflow, zero fill
  logic [prdt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [prdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [prdt_pkg::FRAC_W-1:0]     cfg_data = '0;
  int                              fail_count;
  int                              pending;

  logic [prdt_pkg::SAMPLE_W-1:0]   pulse_q [$];
  int                              items_sent = 0;
  bit                              quiet = 1'b0;
  bit                              rx_quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_rise_decay_time #(
    .MAX_SAMPLES(STORE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pulse_timing_checker #(
    .MAX_SAMPLES(STORE_DEPTH)
  ) u_check (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  task automatic send_word(logic [prdt_pkg::SAMPLE_W-1:0] smp, logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_pulse();
    quiet = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < pulse_q.size(); k++) begin
      send_word(pulse_q[k], k == pulse_q.size() - 1);
    end
    items_sent += pulse_q.size();
  endtask

  // ramp up to the peak and back down after it (inverted for a negative amplitude), optional offset, small noise on top
  function automatic void make_shaped(int len, int pk);
    int amp, base, v;
    amp = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 32000))
                                      : int'($urandom_range(100, 32000));
    base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4000)) - 2000 : 0;
    pulse_q.delete();
    for (int i = 0; i < len; i++) begin
      if (i <= pk) v = amp * (i + 1) / (pk + 1);
      else v = amp * (len - i) / (len - pk);
      v = v + base + int'($urandom_range(0, 40)) - 20;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      pulse_q.push_back(v[prdt_pkg::SAMPLE_W-1:0]);
    end
  endfunction

  function automatic void make_noise(int len);
    pulse_q.delete();
    for (int i = 0; i < len; i++) begin
      pulse_q.push_back(prdt_pkg::SAMPLE_W'($urandom_range(0, 65535)));
    end
  endfunction

  function automatic void make_flat(int len);
    logic [prdt_pkg::SAMPLE_W-1:0] v;
    v = prdt_pkg::SAMPLE_W'($urandom_range(0, 65535));
    pulse_q.delete();
    for (int i = 0; i < len; i++) pulse_q.push_back(v);
  endfunction

  task automatic program_fracs(logic [prdt_pkg::FRAC_W-1:0] rh, logic [prdt_pkg::FRAC_W-1:0] rl,
                               logic [prdt_pkg::FRAC_W-1:0] dh, logic [prdt_pkg::FRAC_W-1:0] dl);
    logic [prdt_pkg::CFG_IDX_W-1:0] idx [5];
    logic [prdt_pkg::FRAC_W-1:0]    val [5];
    idx[0] = prdt_pkg::CFG_RISE_HIGH;
    idx[1] = prdt_pkg::CFG_RISE_LOW;
    idx[2] = prdt_pkg::CFG_DECAY_HIGH;
    idx[3] = prdt_pkg::CFG_DECAY_LOW;
    // stray index, must be ignored
    idx[4] = ($urandom_range(0, 1) == 0) ? '1 :
             prdt_pkg::CFG_IDX_W'($urandom_range(prdt_pkg::NUM_CFG, 255));
    val[0] = rh;
    val[1] = rl;
    val[2] = dh;
    val[3] = dl;
    val[4] = ($urandom_range(0, 1) == 0) ? '1 : prdt_pkg::FRAC_W'($urandom_range(0, 65535));
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_directed();
    pulse_q = '{16'h7fff};
    send_pulse();
    pulse_q = '{16'h8000};
    send_pulse();
    pulse_q = '{16'h0000};
    send_pulse();
    pulse_q = '{16'd100, 16'd500, 16'd1000, 16'd900, 16'd400, 16'd50};
    send_pulse();
    // negative peak
    pulse_q = '{-16'sd5, -16'sd3, -16'sd9};
    send_pulse();
    // equal maxima, first one wins
    pulse_q = '{16'd1000, 16'd1000, 16'd200, 16'd1000};
    send_pulse();
    pulse_q = '{16'd10, 16'd20, 16'd30, 16'd40};
    send_pulse();
    pulse_q = '{16'd0, 16'd0};
    send_pulse();
  endtask

  task automatic run_random(int n_items);
    int start, len, pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      pick = $urandom_range(0, 9);
      if (pick < 7) make_shaped(len, $urandom_range(0, len - 1));
      else if (pick < 9) make_noise(len);
      else make_flat(len);
      send_pulse();
    end
  endtask

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = rx_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(80);
    wait_drained();

    program_fracs('0, '0, '0, '0);
    run_directed();
    run_random(80);
    wait_drained();

    program_fracs('1, '1, '1, '1);
    run_directed();
    run_random(80);
    wait_drained();

    repeat (2) begin
      program_fracs(prdt_pkg::FRAC_W'($urandom_range(0, 65535)),
                    prdt_pkg::FRAC_W'($urandom_range(0, 65535)),
                    prdt_pkg::FRAC_W'($urandom_range(0, 65535)),
                    prdt_pkg::FRAC_W'($urandom_range(0, 65535)));
      run_random(70);
      wait_drained();
    end

    program_fracs('1, '0, '0, '1);
    run_random(80);
    wait_drained();

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("pulse_rise_decay_time test passed");
    end else begin
      $display("pulse_rise_decay_time test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("pulse_rise_decay_time test failed");
    $finish;
  end

endmodule

### sim.f
src/prdt_pkg.sv
src/prdt_ctrl.sv
src/prdt_dp.sv
src/pulse_rise_decay_time.sv
test/pulse_timing_checker.sv
test/tb_top.sv
